// ===== hdl/positional_list_engine_macros.svh =====
// Assertion macros shared by the positional list engine RTL.
// Depends on nothing; included inside module bodies before the logic.
`ifndef POSITIONAL_LIST_ENGINE_MACROS_SVH
`define POSITIONAL_LIST_ENGINE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define PLE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define PLE_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/ple_pkg.sv =====
// Package for the positional list engine: request and response types,
// request, status and cell operation codes. Depends on nothing.
package ple_pkg;

	localparam logic [2:0] REQ_INSERT    = 3'd0;
	localparam logic [2:0] REQ_DEL_FIRST = 3'd1;
	localparam logic [2:0] REQ_DEL_LAST  = 3'd2;
	localparam logic [2:0] REQ_DEL_AT    = 3'd3;
	localparam logic [2:0] REQ_DISPLAY   = 3'd4;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;
	localparam logic [1:0] ST_FULL  = 2'd3;

	// What every cell of the chain does at a clock edge.
	localparam logic [1:0] CELL_HOLD   = 2'd0;
	localparam logic [1:0] CELL_INSERT = 2'd1;
	localparam logic [1:0] CELL_REMOVE = 2'd2;
	localparam logic [1:0] CELL_ROTATE = 2'd3;

	typedef struct packed {
		logic [2:0]         req_type;
		logic [4:0]         position;
		logic signed [31:0] value;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] element;
		logic [4:0]         length;
		logic               last;
	} rsp_t;

endpackage

// ===== hdl/ple_stream_if.sv =====
// Valid/ready stream interface used for the request and response channels.
// The payload type is set per instance; depends on nothing else.
interface ple_stream_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/ple_cell.sv =====
// One storage cell of the list chain: holds one element and picks its next
// value from its neighbors. Depends on ple_pkg.
module ple_cell
	import ple_pkg::*;
#(
	parameter int IDX_W = 4,
	parameter int INDEX = 0
)(
	input  logic               clk,
	input  logic [1:0]         op,
	input  logic [IDX_W-1:0]   key,
	input  logic [IDX_W-1:0]   tail,
	input  logic signed [31:0] new_val,
	input  logic signed [31:0] left_val,
	input  logic signed [31:0] right_val,
	input  logic signed [31:0] head_val,
	output logic signed [31:0] val
);

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

	logic signed [31:0] val_q;
	logic signed [31:0] val_nxt;

	always_comb begin
		val_nxt = val_q;
		case (op)
			CELL_INSERT: begin
				if (MY_IDX == key) begin
					val_nxt = new_val;
				end else if (MY_IDX > key) begin
					val_nxt = left_val;
				end
			end
			CELL_REMOVE: begin
				if (MY_IDX >= key) begin
					val_nxt = right_val;
				end
			end
			CELL_ROTATE: begin
				if (MY_IDX == tail) begin
					val_nxt = head_val;
				end else begin
					val_nxt = right_val;
				end
			end
			default: begin
				val_nxt = val_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		val_q <= val_nxt;
	end

	assign val = val_q;

endmodule

// ===== hdl/positional_list_engine.sv =====
// Top level of the positional list engine: request decode, the cell chain
// and the response register. Depends on ple_pkg, ple_stream_if, ple_cell and
// positional_list_engine_macros.svh.
//
// The list lives in a row of DEPTH cells in list order, cell 0 holding the
// first element. Insert and delete requests are decoded in the cycle of
// their transfer; at that same edge every cell behind the touched position
// takes its neighbor's value, the count is updated and a single response is
// registered. A display request rotates the chain by one place per cycle,
// sending cell 0 out as a response, and stretches while the response side
// stalls; after one turn per element the chain is back in order. A new
// request is taken only when no display is in progress and the response
// register is empty or being drained in the same cycle. A failed request
// leaves the cells and count untouched and reports why in status. Cells are
// not cleared at reset; only cells below the count are ever read, so no
// clearing pass is needed and the block is ready as soon as reset is
// released.
module positional_list_engine
	import ple_pkg::*;
#(
	parameter int DEPTH = 16
)(
	input logic           clk,
	input logic           arst_n,
	ple_stream_if.sink    req,
	ple_stream_if.source  rsp
);

	`include "positional_list_engine_macros.svh"

	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int CMP_W = ((CNT_W > 5) ? CNT_W : 5) + 1;

	localparam logic S_IDLE = 1'b0;
	localparam logic S_DISP = 1'b1;

	logic               state_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [CNT_W-1:0]   emit_q;
	logic               rsp_vld_q;
	rsp_t               rsp_q;

	logic               out_free;
	logic               in_xfer;
	logic [CMP_W-1:0]   pos_x;
	logic [CMP_W-1:0]   cnt_x;
	logic [1:0]         dec_stat;
	logic [1:0]         dec_op;
	logic [IDX_W-1:0]   dec_key;
	logic [CNT_W-1:0]   cnt_nxt;
	logic               dec_disp;
	logic               disp_last;
	logic [1:0]         cell_op;
	logic [IDX_W-1:0]   tail;
	logic signed [31:0] cell_val [DEPTH];

	// The response register can be loaded when it is empty or drained now.
	assign out_free = !rsp_vld_q || rsp.ready;
	assign req.ready = (state_q == S_IDLE) && out_free;
	assign in_xfer = req.valid && req.ready;

	assign pos_x = CMP_W'(req.data.position);
	assign cnt_x = CMP_W'(cnt_q);
	assign tail = IDX_W'(cnt_x - CMP_W'(1));

	// Request decode: status, chain operation, key cell and the new count.
	always_comb begin
		dec_stat = ST_OK;
		dec_op = CELL_HOLD;
		dec_key = '0;
		cnt_nxt = cnt_q;
		dec_disp = 1'b0;
		case (req.data.req_type)
			REQ_INSERT: begin
				if (pos_x == '0 || pos_x > cnt_x + CMP_W'(1)) begin
					dec_stat = ST_RANGE;
				end else if (cnt_q == CNT_W'(DEPTH)) begin
					dec_stat = ST_FULL;
				end else begin
					dec_op = CELL_INSERT;
					dec_key = IDX_W'(pos_x - CMP_W'(1));
					cnt_nxt = cnt_q + CNT_W'(1);
				end
			end
			REQ_DEL_FIRST: begin
				if (cnt_q == '0) begin
					dec_stat = ST_EMPTY;
				end else begin
					dec_op = CELL_REMOVE;
					cnt_nxt = cnt_q - CNT_W'(1);
				end
			end
			REQ_DEL_LAST: begin
				if (cnt_q == '0) begin
					dec_stat = ST_EMPTY;
				end else begin
					dec_op = CELL_REMOVE;
					dec_key = tail;
					cnt_nxt = cnt_q - CNT_W'(1);
				end
			end
			REQ_DEL_AT: begin
				if (cnt_q == '0) begin
					dec_stat = ST_EMPTY;
				end else if (pos_x == '0 || pos_x > cnt_x) begin
					dec_stat = ST_RANGE;
				end else begin
					dec_op = CELL_REMOVE;
					dec_key = IDX_W'(pos_x - CMP_W'(1));
					cnt_nxt = cnt_q - CNT_W'(1);
				end
			end
			REQ_DISPLAY: begin
				if (cnt_q == '0) begin
					dec_stat = ST_EMPTY;
				end else begin
					dec_disp = 1'b1;
				end
			end
			default: begin
				dec_stat = ST_OK;
			end
		endcase
	end

	assign disp_last = (CMP_W'(emit_q) + CMP_W'(1)) == cnt_x;

	// During a display the chain turns only when a response is sent.
	always_comb begin
		if (state_q == S_DISP) begin
			cell_op = out_free ? CELL_ROTATE : CELL_HOLD;
		end else begin
			cell_op = in_xfer ? dec_op : CELL_HOLD;
		end
	end

	// The chain of cells; the outer neighbors of the end cells never matter.
	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		logic signed [31:0] left_v;
		logic signed [31:0] right_v;

		if (g == 0) begin : g_first
			assign left_v = '0;
		end else begin : g_left
			assign left_v = cell_val[g-1];
		end

		if (g == DEPTH - 1) begin : g_end
			assign right_v = '0;
		end else begin : g_right
			assign right_v = cell_val[g+1];
		end

		ple_cell #(
			.IDX_W (IDX_W),
			.INDEX (g)
		) u_cell (
			.clk       (clk),
			.op        (cell_op),
			.key       (dec_key),
			.tail      (tail),
			.new_val   (req.data.value),
			.left_val  (left_v),
			.right_val (right_v),
			.head_val  (cell_val[0]),
			.val       (cell_val[g])
		);
	end

	// Control state: sequencer, element count, display position, valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			emit_q <= '0;
			rsp_vld_q <= 1'b0;
		end else begin
			if (in_xfer) begin
				cnt_q <= cnt_nxt;
			end
			if (out_free) begin
				rsp_vld_q <= (in_xfer && !dec_disp) || (state_q == S_DISP);
			end
			case (state_q)
				S_IDLE: begin
					if (in_xfer && dec_disp) begin
						state_q <= S_DISP;
						emit_q <= '0;
					end
				end
				S_DISP: begin
					if (out_free) begin
						if (disp_last) begin
							state_q <= S_IDLE;
						end else begin
							emit_q <= emit_q + CNT_W'(1);
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Response payload.
	always_ff @(posedge clk) begin
		if (out_free) begin
			if (state_q == S_DISP) begin
				rsp_q.status <= ST_OK;
				rsp_q.element <= cell_val[0];
				rsp_q.length <= 5'(cnt_q);
				rsp_q.last <= disp_last;
			end else if (in_xfer) begin
				rsp_q.status <= dec_stat;
				rsp_q.element <= '0;
				rsp_q.length <= 5'(cnt_nxt);
				rsp_q.last <= 1'b1;
			end
		end
	end

	assign rsp.valid = rsp_vld_q;
	assign rsp.data = rsp_q;

	`PLE_ASSERT_IMP(a_cnt_bound, clk, arst_n, 1'b1, cnt_q <= CNT_W'(DEPTH),
		"element count above capacity")
	`PLE_ASSERT_IMP(a_disp_nonempty, clk, arst_n, state_q == S_DISP, cnt_q != '0,
		"display running on an empty list")
	`PLE_ASSERT_IMP(a_mid_only_disp, clk, arst_n, rsp_vld_q && !rsp_q.last,
		state_q == S_DISP, "non-final response outside a display")
	`PLE_ASSERT_NXT(a_single_rsp, clk, arst_n, in_xfer && !dec_disp, rsp_vld_q,
		"no response after a single-result request")
	`PLE_ASSERT_NXT(a_cnt_hold, clk, arst_n, !in_xfer, $stable(cnt_q),
		"count changed without a request transfer")

endmodule

// ===== verif/positional_list_engine_test.sv =====
// Self-checking testbench for the positional list engine: a directed request script,
// then biased random requests, with every response checked against a list predictor.
// Depends on ple_pkg, ple_stream_if and positional_list_engine.
`timescale 1ns / 100ps

module positional_list_engine_test;
	import ple_pkg::*;

	localparam int CAPACITY     = 16;
	localparam int RANDOM_ITEMS = 450;
	localparam int SEGMENT_LEN  = 30;
	localparam int LONG_STALL   = 80;
	localparam int DRAIN_PAUSE  = 300;

	// Random segments lean toward filling, draining or a mix of both.
	localparam int MODE_FILL  = 0;
	localparam int MODE_DRAIN = 1;
	localparam int MODE_MIX   = 2;

	// Request codes five to seven are unused; the block answers them with a plain ok.
	localparam logic [2:0] REQ_UNUSED_LO = 3'd5;
	localparam logic [2:0] REQ_UNUSED_HI = 3'd7;

	typedef struct {
		req_t       item;
		bit         typed;
		logic [1:0] st;
		logic [4:0] len;
	} script_row_t;

	logic clk;
	logic arst_n;

	ple_stream_if #(.payload_t(req_t)) req_ch ();
	ple_stream_if #(.payload_t(rsp_t)) rsp_ch ();

	positional_list_engine #(.DEPTH(CAPACITY)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Predictor state: the list contents in list order and the element count.
	logic signed [31:0] list_cells [CAPACITY];
	int                 list_len;

	// Responses produced by the latest predicted request, and the responses still
	// awaited from the block, oldest first.
	rsp_t list_rsp [$];
	rsp_t awaited  [$];

	int  mismatches;
	bit  steady_sender;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Hard stop, far beyond the slowest legal run (every request a full display
	// with maximum stalls on both sides is well under this).
	initial begin
		#3200000;
		$display("** positional_list_engine: FAILED **");
		$finish;
	end

	// Drop the cell at index idx and close the gap behind it.
	function automatic void drop_cell(input int idx);
		for (int i = idx; i + 1 < list_len; i++)
			list_cells[i] = list_cells[i + 1];
		list_len--;
	endfunction

	// Apply one request to the predicted list and fill list_rsp with the
	// responses it must cause.
	function automatic void model_request(input req_t r);
		logic [1:0] st;
		int         pos;
		st  = ST_OK;
		pos = int'(r.position);
		list_rsp.delete();
		case (r.req_type)
			REQ_INSERT: begin
				// The position check wins over the full check.
				if (pos == 0 || pos > list_len + 1)
					st = ST_RANGE;
				else if (list_len >= CAPACITY)
					st = ST_FULL;
				else begin
					for (int i = list_len; i >= pos; i--)
						list_cells[i] = list_cells[i - 1];
					list_cells[pos - 1] = r.value;
					list_len++;
				end
			end
			REQ_DEL_FIRST: begin
				if (list_len == 0)
					st = ST_EMPTY;
				else
					drop_cell(0);
			end
			REQ_DEL_LAST: begin
				if (list_len == 0)
					st = ST_EMPTY;
				else
					drop_cell(list_len - 1);
			end
			REQ_DEL_AT: begin
				if (list_len == 0)
					st = ST_EMPTY;
				else if (pos == 0 || pos > list_len)
					st = ST_RANGE;
				else
					drop_cell(pos - 1);
			end
			REQ_DISPLAY: begin
				if (list_len == 0) begin
					list_rsp.push_back('{ST_EMPTY, 32'sd0, 5'd0, 1'b1});
				end else begin
					for (int i = 0; i < list_len; i++)
						list_rsp.push_back('{ST_OK, list_cells[i], 5'(list_len),
							(i == list_len - 1)});
				end
				return;
			end
			default: st = ST_OK;
		endcase
		list_rsp.push_back('{st, 32'sd0, 5'(list_len), 1'b1});
	endfunction

	function automatic script_row_t row(input logic [2:0] rt, input logic [4:0] pos,
		input logic [31:0] val, input bit typed, input logic [1:0] st, input logic [4:0] len);
		script_row_t s;
		s.item  = '{rt, pos, val};
		s.typed = typed;
		s.st    = st;
		s.len   = len;
		return s;
	endfunction

	// Draw one random request. Most positions are legal for the current length so
	// the list actually moves; about one in ten is anywhere in the field's range.
	function automatic script_row_t draw_request(input int mode);
		script_row_t s;
		int          pick;
		int          ins_pct;
		pick    = $urandom_range(0, 99);
		ins_pct = (mode == MODE_FILL) ? 80 : (mode == MODE_DRAIN) ? 15 : 45;
		s.typed = 1'b0;
		s.st    = ST_OK;
		s.len   = '0;
		if (pick < ins_pct)
			s.item.req_type = REQ_INSERT;
		else if (pick < ins_pct + 10)
			s.item.req_type = REQ_DISPLAY;
		else if (pick < 97) begin
			case ($urandom_range(0, 2))
				0:       s.item.req_type = REQ_DEL_FIRST;
				1:       s.item.req_type = REQ_DEL_LAST;
				default: s.item.req_type = REQ_DEL_AT;
			endcase
		end else
			s.item.req_type = 3'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI));

		if ($urandom_range(0, 9) == 0)
			s.item.position = 5'($urandom_range(0, 31));
		else if (s.item.req_type == REQ_INSERT)
			s.item.position = 5'($urandom_range(1, list_len + 1));
		else if (s.item.req_type == REQ_DEL_AT && list_len > 0)
			s.item.position = 5'($urandom_range(1, list_len));
		else
			s.item.position = 5'($urandom_range(0, 31));

		case ($urandom_range(0, 9))
			0:       s.item.value = 32'sh7FFF_FFFF;
			1:       s.item.value = 32'sh8000_0000;
			default: s.item.value = $urandom();
		endcase
		return s;
	endfunction

	// Offer one request and record what it must cause once it transfers. With
	// hold_for_drain set, the offer waits first until every awaited response is in.
	task automatic offer(input script_row_t s, input bit hold_for_drain);
		int gap;
		gap = steady_sender ? 0 : $urandom_range(0, 4);
		if (hold_for_drain) begin
			req_ch.valid <= 1'b0;
			do @(posedge clk); while (awaited.size() != 0);
		end
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.data  <= s.item;
		do @(posedge clk); while (!(req_ch.valid && req_ch.ready));
		// The response to this transfer is registered at this same edge, so it
		// cannot be sampled before the expectation below is queued.
		model_request(s.item);
		if (s.typed)
			awaited.push_back('{s.st, 32'sd0, s.len, 1'b1});
		else
			foreach (list_rsp[k])
				awaited.push_back(list_rsp[k]);
	endtask

	// Response side: a random hold-off before each transfer, stretches with none,
	// and one long stall so the block backs up and stops taking requests.
	initial begin
		int  gap;
		int  taken;
		bit  steady;
		taken  = 0;
		steady = 1'b0;
		rsp_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (taken % 40 == 0)
				steady = ($urandom_range(0, 3) == 0);
			if (taken == 100)
				gap = LONG_STALL;
			else
				gap = steady ? 0 : $urandom_range(0, 4);
			if (gap > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!(rsp_ch.valid && rsp_ch.ready));
			taken++;
		end
	end

	// Response checker: every transfer is matched field by field against the
	// oldest awaited response.
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (awaited.size() == 0) begin
				$error("response transfer with none awaited: status %0d element %0d",
					rsp_ch.data.status, rsp_ch.data.element);
				mismatches++;
			end else begin
				want = awaited.pop_front();
				if (rsp_ch.data.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, rsp_ch.data.status);
					mismatches++;
				end
				if (rsp_ch.data.element !== want.element) begin
					$error("element: expected %0d, got %0d", want.element,
						rsp_ch.data.element);
					mismatches++;
				end
				if (rsp_ch.data.length !== want.length) begin
					$error("length: expected %0d, got %0d", want.length, rsp_ch.data.length);
					mismatches++;
				end
				if (rsp_ch.data.last !== want.last) begin
					$error("last: expected %0d, got %0d", want.last, rsp_ch.data.last);
					mismatches++;
				end
			end
		end
	end

	initial begin
		script_row_t script [$];
		int          mode;

		mismatches    = 0;
		steady_sender = 1'b0;
		list_len      = 0;
		arst_n        = 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.data  <= '0;

		// Directed script. Single-result rows whose answer is plain from the list
		// state carry it here; displays go through the predictor.
		script = '{
			// Everything on an empty list fails with list empty.
			row(REQ_DISPLAY,   5'd0,  32'h0,         1, ST_EMPTY, 5'd0),
			row(REQ_DEL_FIRST, 5'd0,  32'h0,         1, ST_EMPTY, 5'd0),
			row(REQ_DEL_LAST,  5'd31, 32'h0,         1, ST_EMPTY, 5'd0),
			row(REQ_DEL_AT,    5'd1,  32'h0,         1, ST_EMPTY, 5'd0),
			// Insert at position zero and past the end.
			row(REQ_INSERT,    5'd0,  32'h1234_5678, 1, ST_RANGE, 5'd0),
			row(REQ_INSERT,    5'd2,  32'h1234_5678, 1, ST_RANGE, 5'd0),
			// Build a list of extreme values at the head, the tail and the middle.
			row(REQ_INSERT,    5'd1,  32'h7FFF_FFFF, 1, ST_OK,    5'd1),
			row(REQ_INSERT,    5'd2,  32'h8000_0000, 1, ST_OK,    5'd2),
			row(REQ_INSERT,    5'd1,  32'hFFFF_FFFF, 1, ST_OK,    5'd3),
			row(REQ_INSERT,    5'd2,  32'h0000_0000, 1, ST_OK,    5'd4),
			row(REQ_INSERT,    5'd5,  32'h5A5A_A5A5, 1, ST_OK,    5'd5),
			row(REQ_DISPLAY,   5'd0,  32'h0,         0, ST_OK,    5'd0),
			// Delete at position zero and past the end, then a real one.
			row(REQ_DEL_AT,    5'd6,  32'h0,         1, ST_RANGE, 5'd5),
			row(REQ_DEL_AT,    5'd0,  32'h0,         1, ST_RANGE, 5'd5),
			row(REQ_DEL_AT,    5'd31, 32'h0,         1, ST_RANGE, 5'd5),
			row(REQ_DEL_AT,    5'd3,  32'h0,         1, ST_OK,    5'd4),
			row(REQ_DISPLAY,   5'd0,  32'h0,         0, ST_OK,    5'd0),
			row(REQ_DEL_FIRST, 5'd0,  32'h0,         1, ST_OK,    5'd3),
			row(REQ_DEL_LAST,  5'd0,  32'h0,         1, ST_OK,    5'd2),
			// Unused request codes change nothing.
			row(3'd5,          5'd31, 32'hFFFF_FFFF, 1, ST_OK,    5'd2),
			row(3'd6,          5'd16, 32'h8000_0000, 1, ST_OK,    5'd2),
			row(3'd7,          5'd1,  32'h7FFF_FFFF, 1, ST_OK,    5'd2),
			row(REQ_DISPLAY,   5'd0,  32'h0,         0, ST_OK,    5'd0)
		};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i]) begin
			if (i % 8 == 0)
				steady_sender = ($urandom_range(0, 3) == 0);
			offer(script[i], 1'b0);
		end

		// Random part. The first segment fills the list so that inserts into a full
		// list come early; later segments pick a leaning at random.
		mode = MODE_FILL;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % SEGMENT_LEN == 0 && n > 0)
				mode = $urandom_range(MODE_FILL, MODE_MIX);
			if (n % 25 == 0)
				steady_sender = ($urandom_range(0, 3) == 0);
			offer(draw_request(mode), n == DRAIN_PAUSE);
		end
		req_ch.valid <= 1'b0;

		while (awaited.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		if (mismatches == 0 && awaited.size() == 0)
			$display("** positional_list_engine: PASSED **");
		else
			$display("** positional_list_engine: FAILED **");
		$finish;
	end

endmodule

// ===== positional_list_engine.f =====
+incdir+hdl
hdl/ple_pkg.sv
hdl/ple_stream_if.sv
hdl/ple_cell.sv
hdl/positional_list_engine.sv
verif/positional_list_engine_test.sv
